// ===== hw/rtl/bilinear_texel_sampler_top_defines.svh =====
// assertion macros used by the bilinear texel sampler rtl
`ifndef BILINEAR_TEXEL_SAMPLER_TOP_DEFINES_SVH
`define BILINEAR_TEXEL_SAMPLER_TOP_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define BTS_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bts assertion failed");

// next-cycle implication
`define BTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bts assertion failed");

`else

`define BTS_ASSERT(lbl, clk, rstn, ante, cons)
`define BTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/bts_pkg.sv =====
// types and constants of the bilinear texel sampler
package bts_pkg;

    localparam int unsigned CH_W     = 16;
    localparam int unsigned NUM_CH   = 4;
    localparam int unsigned IDX_W    = 12;
    localparam int unsigned CFG_W    = 7;
    localparam int unsigned COORD_W  = 32;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned WFB      = 8;
    localparam int unsigned WT_W     = 2 * WFB + 1;
    localparam int unsigned ACC_W    = 2 * WFB + CH_W + 1;
    localparam int unsigned AXIS_W   = FRAC_W + CFG_W;
    localparam int unsigned ROW_W    = 2 * CFG_W;
    localparam int unsigned APB_W    = 32;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned REG_SEL_BIT = 2;

    localparam logic [CFG_W-1:0] TEX_SIZE_RST = 7'd64;
    localparam logic [1:0]       LAST_TAP     = 2'd3;

    // register selects
    localparam logic REG_TEX_WIDTH  = 1'b0;
    localparam logic REG_TEX_HEIGHT = 1'b1;

    // request types
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_texel;

    typedef struct packed {
        logic                      req_type;
        logic [IDX_W-1:0]          texel_index;
        logic [CH_W-1:0]           in_ch0;
        logic [CH_W-1:0]           in_ch1;
        logic [CH_W-1:0]           in_ch2;
        logic [CH_W-1:0]           in_ch3;
        logic signed [COORD_W-1:0] coord_u;
        logic signed [COORD_W-1:0] coord_v;
    } t_in_req;

    typedef struct packed {
        logic [CH_W-1:0] out_ch0;
        logic [CH_W-1:0] out_ch1;
        logic [CH_W-1:0] out_ch2;
        logic [CH_W-1:0] out_ch3;
    } t_out_res;

    // one request after tap and weight setup
    typedef struct packed {
        logic                      is_smp;
        logic [IDX_W-1:0]          waddr;
        t_texel                    wdata;
        logic [ROW_W-1:0]          row0;
        logic [ROW_W-1:0]          row1;
        logic [CFG_W-1:0]          x0;
        logic [CFG_W-1:0]          x1;
        logic [NUM_CH-1:0][WT_W-1:0] wt;
    } t_tap_req;

    // tap read control toward the blend unit
    typedef struct packed {
        logic            vld;
        logic            first;
        logic            last;
        logic [WT_W-1:0] wt;
    } t_rd_ctl;

endpackage

// ===== hw/rtl/bilinear_texel_sampler_top.sv =====
// top level of the bilinear texel sampler
//
// Bilinear texture sampler with clamp-to-edge addressing over a single-port
// texel memory of TEX_MAX_W*TEX_MAX_H entries, each four 16-bit channels.
// A write request (req_type 0) stores one texel at texel_index and gives no
// result; indices at or beyond the memory depth are dropped. A sample request
// (req_type 1) wraps coord_u/coord_v (signed Q16.16) to their fraction, scales
// by the texture size, backs off half a texel, clamps the four neighbor taps
// to the edge and returns the 8-bit-weighted blend per channel, rounded half
// up. A sample holds the texel memory port for its four tap reads (one tap read
// per cycle); a write holds it for a single access. Requests behind them wait
// in the setup stages. Two result slots let up to two samples run ahead of
// a stalled output. tex_width/tex_height sit at byte addresses 0 and 4, reset
// to 64, act as 1 when 0 and clip to the maximum size (a read returns the
// stored value); change them only while idle.
// Sampling a texel that was never written returns undefined data. The texel
// memory has no reset.
module bilinear_texel_sampler_top #(
    parameter int unsigned TEX_MAX_W = 64,
    parameter int unsigned TEX_MAX_H = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_req_valid,
    output logic                           o_req_stall,
    input  bts_pkg::t_in_req               i_req,
    // result channel
    output logic                           o_res_valid,
    input  logic                           i_res_stall,
    output bts_pkg::t_out_res              o_res,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bts_pkg::PADDR_W-1:0]    paddr,
    input  logic [bts_pkg::APB_W-1:0]      pwdata,
    output logic [bts_pkg::APB_W-1:0]      prdata,
    output logic                           pready
);
    import bts_pkg::*;

    localparam int unsigned DEPTH = TEX_MAX_W * TEX_MAX_H;
    localparam int unsigned AW    = $clog2(DEPTH);

    // configuration registers
    logic [CFG_W-1:0] r_tex_w, r_tex_h;
    logic [CFG_W-1:0] w_eff, h_eff;
    logic             cfg_wr;

    // sequencer
    logic             r_sq_vld;
    t_tap_req         r_sq;
    logic [1:0]       r_tap;
    logic             tap_vld, take, seq_go, seq_done, idx_ok;
    t_tap_req         tap_req;
    logic [ROW_W-1:0] rd_addr;

    // memory port and blend
    logic             mem_en, mem_we;
    logic [AW-1:0]    mem_addr;
    t_texel           mem_rdata;
    t_rd_ctl          rd_ctl;
    logic             room;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= TEX_SIZE_RST;
            r_tex_h <= TEX_SIZE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[REG_SEL_BIT])
                REG_TEX_WIDTH:  r_tex_w <= pwdata[CFG_W-1:0];
                REG_TEX_HEIGHT: r_tex_h <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[REG_SEL_BIT])
            REG_TEX_WIDTH:  prdata = APB_W'(r_tex_w);
            REG_TEX_HEIGHT: prdata = APB_W'(r_tex_h);
        endcase
    end

    // effective sizes: zero acts as one, large values clip to the maximum
    always_comb begin
        if (r_tex_w == '0) begin
            w_eff = CFG_W'(1);
        end else if (32'(r_tex_w) > TEX_MAX_W) begin
            w_eff = CFG_W'(TEX_MAX_W);
        end else begin
            w_eff = r_tex_w;
        end
        if (r_tex_h == '0) begin
            h_eff = CFG_W'(1);
        end else if (32'(r_tex_h) > TEX_MAX_H) begin
            h_eff = CFG_W'(TEX_MAX_H);
        end else begin
            h_eff = r_tex_h;
        end
    end

    // ---------------- tap setup ----------------
    bts_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req_valid),
        .o_stall (o_req_stall),
        .i_req   (i_req),
        .i_w     (w_eff),
        .i_h     (h_eff),
        .o_valid (tap_vld),
        .i_take  (take),
        .o_tap   (tap_req)
    );

    // ---------------- memory sequencer ----------------
    // a sample owns the port for four tap reads, a write for a single access;
    // the first tap waits for a free result slot so nothing is ever dropped
    assign seq_go   = r_sq_vld && (!r_sq.is_smp || (r_tap != 2'd0) || room);
    assign seq_done = seq_go && (!r_sq.is_smp || (r_tap == LAST_TAP));
    assign take     = !r_sq_vld || seq_done;
    assign idx_ok   = (32'(r_sq.waddr) < DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
            r_tap    <= 2'd0;
        end else begin
            if (take) begin
                r_sq_vld <= tap_vld;
                r_tap    <= 2'd0;
            end else if (seq_go && r_sq.is_smp) begin
                r_tap <= r_tap + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && tap_vld) begin
            r_sq <= tap_req;
        end
    end

    // tap order: top-left, top-right, bottom-left, bottom-right
    assign rd_addr = (r_tap[1] ? r_sq.row1 : r_sq.row0)
                   + ROW_W'(r_tap[0] ? r_sq.x1 : r_sq.x0);

    assign mem_en   = seq_go && (r_sq.is_smp || idx_ok);
    assign mem_we   = !r_sq.is_smp;
    assign mem_addr = r_sq.is_smp ? AW'(rd_addr) : AW'(r_sq.waddr);

    assign rd_ctl.vld   = seq_go && r_sq.is_smp;
    assign rd_ctl.first = (r_tap == 2'd0);
    assign rd_ctl.last  = (r_tap == LAST_TAP);
    assign rd_ctl.wt    = r_sq.wt[r_tap];

    bts_texmem #(
        .DEPTH (DEPTH)
    ) u_texmem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (r_sq.wdata),
        .o_rdata (mem_rdata)
    );

    // ---------------- blend and result slots ----------------
    bts_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rd_ctl),
        .i_rdata (mem_rdata),
        .o_room  (room),
        .o_valid (o_res_valid),
        .i_stall (i_res_stall),
        .o_res   (o_res)
    );

endmodule

// ===== hw/rtl/bts_texmem.sv =====
// single-port texel memory with registered read data
module bts_texmem #(
    parameter int unsigned DEPTH = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    input  bts_pkg::t_texel            i_wdata,
    output bts_pkg::t_texel            o_rdata
);
    import bts_pkg::*;

    t_texel r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

// ===== hw/rtl/bts_addr.sv =====
// two-stage tap position and weight setup
module bts_addr (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  bts_pkg::t_in_req            i_req,
    input  logic [bts_pkg::CFG_W-1:0]   i_w,
    input  logic [bts_pkg::CFG_W-1:0]   i_h,
    output logic                        o_valid,
    input  logic                        i_take,
    output bts_pkg::t_tap_req           o_tap
);
    import bts_pkg::*;

    localparam logic [AXIS_W-1:0] HALF_TEXEL = AXIS_W'(32'h8000);
    localparam logic [WFB:0]      WSCALE     = {1'b1, {WFB{1'b0}}};

    logic             r_s1_vld;
    logic             r_s1_smp;
    logic [IDX_W-1:0] r_s1_idx;
    t_texel           r_s1_data;
    logic [CFG_W-1:0] r_s1_ibx, r_s1_iby;
    logic [WFB-1:0]   r_s1_fx, r_s1_fy;
    logic             r_s2_vld;
    t_tap_req         r_s2;

    logic             s2_free, accept;
    logic [AXIS_W-1:0] px, py, bx, by;
    logic [CFG_W-1:0] x0, x1, y0, y1;
    logic [WFB:0]     nfx, nfy, efx, efy;
    t_tap_req         n_s2;

    assign s2_free = !r_s2_vld || i_take;
    assign o_stall = r_s1_vld && !s2_free;
    assign accept  = i_valid && !o_stall;

    // stage 1: fraction times size, half texel back off (kept biased by one texel)
    always_comb begin
        px = i_req.coord_u[FRAC_W-1:0] * i_w;
        py = i_req.coord_v[FRAC_W-1:0] * i_h;
        bx = px + HALF_TEXEL;
        by = py + HALF_TEXEL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s2_free) begin
                r_s1_vld <= 1'b0;
            end
            if (s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_smp  <= (i_req.req_type == REQ_SAMPLE);
            r_s1_idx  <= i_req.texel_index;
            r_s1_data <= {i_req.in_ch3, i_req.in_ch2, i_req.in_ch1, i_req.in_ch0};
            r_s1_ibx  <= bx[FRAC_W +: CFG_W];
            r_s1_iby  <= by[FRAC_W +: CFG_W];
            r_s1_fx   <= bx[FRAC_W-1 -: WFB];
            r_s1_fy   <= by[FRAC_W-1 -: WFB];
        end
        if (s2_free && r_s1_vld) begin
            r_s2 <= n_s2;
        end
    end

    // stage 2: clamp taps to the edge, row bases, weights
    always_comb begin
        x0  = (r_s1_ibx == '0) ? '0 : r_s1_ibx - 1'b1;
        x1  = (r_s1_ibx >= i_w) ? i_w - 1'b1 : r_s1_ibx;
        y0  = (r_s1_iby == '0) ? '0 : r_s1_iby - 1'b1;
        y1  = (r_s1_iby >= i_h) ? i_h - 1'b1 : r_s1_iby;
        efx = {1'b0, r_s1_fx};
        efy = {1'b0, r_s1_fy};
        nfx = WSCALE - efx;
        nfy = WSCALE - efy;
        n_s2.is_smp = r_s1_smp;
        n_s2.waddr  = r_s1_idx;
        n_s2.wdata  = r_s1_data;
        n_s2.row0   = y0 * i_w;
        n_s2.row1   = y1 * i_w;
        n_s2.x0     = x0;
        n_s2.x1     = x1;
        n_s2.wt[0]  = nfx * nfy;
        n_s2.wt[1]  = efx * nfy;
        n_s2.wt[2]  = nfx * efy;
        n_s2.wt[3]  = efx * efy;
    end

    assign o_valid = r_s2_vld;
    assign o_tap   = r_s2;

endmodule

// ===== hw/rtl/bts_blend.sv =====
// per-channel weighted accumulation and two-entry result queue
`include "bilinear_texel_sampler_top_defines.svh"

module bts_blend (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bts_pkg::t_rd_ctl   i_ctl,
    input  bts_pkg::t_texel    i_rdata,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output bts_pkg::t_out_res  o_res
);
    import bts_pkg::*;

    localparam logic [ACC_W-1:0] RND = ACC_W'({1'b1, {(2*WFB-1){1'b0}}});

    logic                         r_rd_vld, r_rd_first, r_rd_last;
    logic [WT_W-1:0]              r_rd_wt;
    logic [NUM_CH-1:0][ACC_W-1:0] r_acc;
    logic [NUM_CH-1:0][ACC_W-1:0] n_prod, n_sum;
    t_out_res                     r_q [2];
    logic                         r_wp, r_rp;
    logic [1:0]                   r_cnt, r_infl;
    logic                         push, pop, start;
    logic [2:0]                   occ;
    t_out_res                     res;

    assign start = i_ctl.vld && i_ctl.first;
    assign push  = r_rd_vld && r_rd_last;
    assign pop   = o_valid && !i_stall;
    assign occ   = {1'b0, r_cnt} + {1'b0, r_infl};
    assign o_room  = (occ < 3'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_q[r_rp];

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            n_prod[k] = i_rdata[k] * r_rd_wt;
            n_sum[k]  = (r_rd_first ? RND : r_acc[k]) + n_prod[k];
        end
        res.out_ch0 = n_sum[0][2*WFB +: CH_W];
        res.out_ch1 = n_sum[1][2*WFB +: CH_W];
        res.out_ch2 = n_sum[2][2*WFB +: CH_W];
        res.out_ch3 = n_sum[3][2*WFB +: CH_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= 2'd0;
            r_infl   <= 2'd0;
        end else begin
            r_rd_vld <= i_ctl.vld;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt  <= r_cnt + 2'(push) - 2'(pop);
            r_infl <= r_infl + 2'(start) - 2'(push);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= i_ctl.first;
        r_rd_last  <= i_ctl.last;
        r_rd_wt    <= i_ctl.wt;
        if (r_rd_vld) begin
            r_acc <= n_sum;
        end
        if (push) begin
            r_q[r_wp] <= res;
        end
    end

    `BTS_ASSERT(a_occ_bound, i_clk, i_rst_n, 1'b1, occ <= 3'd2)
    `BTS_ASSERT(a_start_room, i_clk, i_rst_n, start, o_room)
    `BTS_ASSERT(a_push_owned, i_clk, i_rst_n, push, r_infl != 2'd0)
    `BTS_ASSERT_NEXT(a_taps_follow, i_clk, i_rst_n, start, i_ctl.vld && !i_ctl.first)

endmodule

// ===== tb/bts_blend_checker.sv =====
// prediction and checking of filtered samples for the bilinear texel sampler
module bts_blend_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_stall,
    input  bts_pkg::t_in_req            i_req,
    input  logic                        i_res_valid,
    input  logic                        i_res_stall,
    input  bts_pkg::t_out_res           i_res,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [bts_pkg::PADDR_W-1:0] i_paddr,
    input  logic [bts_pkg::APB_W-1:0]   i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_sample_count,
    output int                          o_write_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import bts_pkg::*;

    localparam int unsigned MAX_W     = 64;
    localparam int unsigned MAX_H     = 64;
    localparam int unsigned MEM_DEPTH = MAX_W * MAX_H;
    localparam int unsigned W_ONE     = 1 << WFB;
    localparam int          PRINT_CAP = 40;

    typedef struct {
        int          tap;
        int unsigned frac;
    } t_axis;

    // mirror of the texel memory and of the size registers
    logic [CH_W-1:0]  texel_mirror [MEM_DEPTH][NUM_CH];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_out_res         blend_q [$];

    function automatic int unsigned limit_size(logic [CFG_W-1:0] v, int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic t_axis axis_split(logic [COORD_W-1:0] c, int unsigned size);
        t_axis            a;
        longint unsigned  biased;
        biased = longint'(c[FRAC_W-1:0]) * size + 64'h8000;
        a.tap  = int'(biased >> FRAC_W) - 1;
        a.frac = int'((biased >> (FRAC_W - WFB)) & (W_ONE - 1));
        return a;
    endfunction

    function automatic int unsigned edge_clamp(int t, int unsigned size);
        if (t < 0) return 0;
        if (t > int'(size) - 1) return size - 1;
        return t;
    endfunction

    function automatic t_out_res blend_sample(t_in_req r);
        int unsigned     w_sz, h_sz, x0, x1, y0, y1;
        int unsigned     addr [4];
        int unsigned     wt [4];
        longint unsigned acc;
        logic [CH_W-1:0] ch [NUM_CH];
        t_axis           ax, ay;
        t_out_res        res;
        w_sz = limit_size(width_reg, MAX_W);
        h_sz = limit_size(height_reg, MAX_H);
        ax = axis_split(r.coord_u, w_sz);
        ay = axis_split(r.coord_v, h_sz);
        x0 = edge_clamp(ax.tap, w_sz);
        x1 = edge_clamp(ax.tap + 1, w_sz);
        y0 = edge_clamp(ay.tap, h_sz);
        y1 = edge_clamp(ay.tap + 1, h_sz);
        addr[0] = y0 * w_sz + x0;
        addr[1] = y0 * w_sz + x1;
        addr[2] = y1 * w_sz + x0;
        addr[3] = y1 * w_sz + x1;
        wt[0] = (W_ONE - ax.frac) * (W_ONE - ay.frac);
        wt[1] = ax.frac * (W_ONE - ay.frac);
        wt[2] = (W_ONE - ax.frac) * ay.frac;
        wt[3] = ax.frac * ay.frac;
        for (int k = 0; k < NUM_CH; k++) begin
            acc = 64'd1 << (2 * WFB - 1);
            for (int t = 0; t < 4; t++)
                acc += longint'(texel_mirror[addr[t]][k]) * wt[t];
            ch[k] = CH_W'(acc >> (2 * WFB));
        end
        res.out_ch0 = ch[0];
        res.out_ch1 = ch[1];
        res.out_ch2 = ch[2];
        res.out_ch3 = ch[3];
        return res;
    endfunction

    task automatic report_failure(input string msg);
        if (o_fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic compare_result(input t_out_res got, input t_out_res want);
        logic [CH_W-1:0] g [NUM_CH];
        logic [CH_W-1:0] w [NUM_CH];
        g = '{got.out_ch0, got.out_ch1, got.out_ch2, got.out_ch3};
        w = '{want.out_ch0, want.out_ch1, want.out_ch2, want.out_ch3};
        for (int k = 0; k < NUM_CH; k++)
            if (g[k] !== w[k])
                report_failure($sformatf("sample %0d out_ch%0d got %h expected %h",
                                         o_sample_count, k, g[k], w[k]));
    endtask

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_sample_count = 0;
        o_write_count  = 0;
        width_reg      = TEX_SIZE_RST;
        height_reg     = TEX_SIZE_RST;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = TEX_SIZE_RST;
            height_reg = TEX_SIZE_RST;
            blend_q.delete();
        end else begin
            // results first: a result never belongs to a request taken at the same edge
            if (i_res_valid && !i_res_stall) begin
                if (blend_q.size() == 0)
                    report_failure($sformatf("result %h with no sample outstanding", i_res));
                else
                    compare_result(i_res, blend_q.pop_front());
                o_sample_count++;
            end
            if (i_req_valid && !i_req_stall) begin
                if (i_req.req_type == REQ_WRITE) begin
                    if (i_req.texel_index < MEM_DEPTH) begin
                        texel_mirror[i_req.texel_index][0] = i_req.in_ch0;
                        texel_mirror[i_req.texel_index][1] = i_req.in_ch1;
                        texel_mirror[i_req.texel_index][2] = i_req.in_ch2;
                        texel_mirror[i_req.texel_index][3] = i_req.in_ch3;
                    end
                    o_write_count++;
                end else begin
                    blend_q.push_back(blend_sample(i_req));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[REG_SEL_BIT] == REG_TEX_WIDTH)
                    width_reg = i_pwdata[CFG_W-1:0];
                else
                    height_reg = i_pwdata[CFG_W-1:0];
            end
        end
        o_pending = blend_q.size();
    end

endmodule

// ===== tb/tb_bilinear_texel_sampler_top.sv =====
// stimulus and verdict for the bilinear texel sampler
module tb_bilinear_texel_sampler_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bts_pkg::*;

    localparam int unsigned MAX_W       = 64;
    localparam int unsigned MAX_H       = 64;
    localparam int unsigned MEM_DEPTH   = MAX_W * MAX_H;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 90;
    localparam int          SETTLE      = 16;
    localparam int          CYCLE_LIMIT = 1000000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                req_valid   = 1'b0;
    logic                req_stall;
    t_in_req             req_bus     = '0;
    logic                res_valid;
    logic                res_stall   = 1'b0;
    t_out_res            res_bus;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [APB_W-1:0]    pwdata      = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    int                  fail_count, pending, sample_count, write_count;
    int                  cycle_count = 0;
    int                  send_calm   = 0;
    int                  recv_calm   = 0;
    bit                  texel_written [MEM_DEPTH];

    // size settings per phase: small first, clamped values (0 and 127),
    // full 64 along either axis, and a mid-size 23x37 texture last
    int unsigned         phase_w [PHASES] = '{4, 1, 0, 64, 1, 127, 2, 23};
    int unsigned         phase_h [PHASES] = '{3, 1, 0, 1, 64, 5, 127, 37};

    bilinear_texel_sampler_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req_bus),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_res       (res_bus),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    bts_blend_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (req_valid),
        .i_req_stall    (req_stall),
        .i_req          (req_bus),
        .i_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .i_res          (res_bus),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_sample_count (sample_count),
        .o_write_count  (write_count)
    );

    // 100 MHz clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d samples outstanding", cycle_count, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stall before each result, with calm stretches
    // where results are taken back to back
    initial begin
        int unsigned gap;
        forever begin
            if (recv_calm > 0) begin
                gap = 0;
                recv_calm--;
            end else if ($urandom_range(0, 15) == 0) begin
                gap = 0;
                recv_calm = $urandom_range(10, 40);
            end else begin
                gap = $urandom_range(0, 17);
            end
            if (gap > 0) begin
                res_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            res_stall <= 1'b0;
            do @(posedge i_clk); while (!(res_valid && !res_stall));
        end
    end

    function automatic int unsigned eff_size(int unsigned v, int unsigned top);
        v = v & ((1 << CFG_W) - 1);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    // channel values lean on the extremes now and then
    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom());
        endcase
    endfunction

    // coordinates: fully random or with the fraction pushed near 0 / near 1
    // so the taps land on the clamp at either edge
    function automatic logic [COORD_W-1:0] rand_coord();
        logic [FRAC_W-1:0] hi;
        hi = FRAC_W'($urandom());
        case ($urandom_range(0, 3))
            2:       return {hi, FRAC_W'($urandom_range(0, 255))};
            3:       return {hi, FRAC_W'(16'hFFFF - $urandom_range(0, 255))};
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // write request; coordinate fields carry noise the block must ignore
    function automatic t_in_req write_req(int unsigned idx, logic [CH_W-1:0] c0,
                                          logic [CH_W-1:0] c1, logic [CH_W-1:0] c2,
                                          logic [CH_W-1:0] c3);
        t_in_req r;
        r.req_type    = REQ_WRITE;
        r.texel_index = IDX_W'(idx);
        r.in_ch0      = c0;
        r.in_ch1      = c1;
        r.in_ch2      = c2;
        r.in_ch3      = c3;
        r.coord_u     = COORD_W'($urandom());
        r.coord_v     = COORD_W'($urandom());
        return r;
    endfunction

    // sample request; index and channel fields are noise
    function automatic t_in_req sample_req(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        t_in_req r;
        r.req_type    = REQ_SAMPLE;
        r.texel_index = IDX_W'($urandom());
        r.in_ch0      = CH_W'($urandom());
        r.in_ch1      = CH_W'($urandom());
        r.in_ch2      = CH_W'($urandom());
        r.in_ch3      = CH_W'($urandom());
        r.coord_u     = u;
        r.coord_v     = v;
        return r;
    endfunction

    // one request: random gap with valid low, then hold until taken
    task automatic send_req(input t_in_req r);
        int unsigned gap;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else if ($urandom_range(0, 15) == 0) begin
            gap = 0;
            send_calm = $urandom_range(10, 40);
        end else begin
            gap = $urandom_range(0, 17);
        end
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_bus   <= r;
        do @(posedge i_clk); while (req_stall);
        if (r.req_type == REQ_WRITE)
            texel_written[r.texel_index] = 1'b1;
    endtask

    // stop sending, wait for every sample back, then let trailing writes land
    task automatic settle_idle();
        req_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic sel, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(sel) << REG_SEL_BIT;
        // upper data bits are noise above the 7-bit size field
        pwdata  <= {(APB_W - CFG_W)'($urandom()), CFG_W'(value)};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // every texel a sample can reach under the current size gets written first
    task automatic fill_region(input int unsigned area);
        for (int unsigned i = 0; i < area; i++)
            if (!texel_written[i])
                send_req(write_req(i, rand_chan(), rand_chan(), rand_chan(), rand_chan()));
    endtask

    // hand-picked requests at the 4x3 size: channel extremes, max index,
    // clamp at both edges, signed coordinate extremes, exact texel center
    task automatic directed_part();
        send_req(write_req(0, '1, '1, '1, '1));
        send_req(write_req(MEM_DEPTH - 1, '0, '1, '0, '1));
        send_req(write_req(1, '0, '0, '0, '0));
        send_req(write_req(4, 16'h8001, 16'h7FFF, 16'h0001, 16'hFFFE));
        send_req(sample_req(32'h0000_0000, 32'h0000_0000));
        send_req(sample_req(32'h0000_FFFF, 32'h0000_FFFF));
        send_req(sample_req(32'h7FFF_FFFF, 32'h8000_0000));
        send_req(sample_req(32'hFFFF_FFFF, 32'h0000_8000));
        send_req(sample_req(32'h0000_4000, 32'h0000_C000));
        // center of texel 0 horizontally: zero fraction weight
        send_req(sample_req(32'h0000_2000, 32'h0000_2AAB));
        // halfway between texels 0 and 1, exercising half-up rounding
        send_req(sample_req(32'h0000_4000, 32'h0000_2AAB));
        send_req(sample_req(32'h8000_6000, 32'hFFFF_5555));
        send_req(write_req(2, '1, '0, '1, '0));
        send_req(sample_req(32'h0000_6000, 32'h0001_0000));
        send_req(sample_req(32'h1234_9FFF, 32'hEDCB_7FFF));
    endtask

    // random mix: mostly samples, writes inside and outside the live region
    task automatic random_part(input int unsigned area, input bit mid_pause);
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (mid_pause && k == PHASE_ITEMS / 2)
                settle_idle();
            if ($urandom_range(0, 99) < 30) begin
                if ($urandom_range(0, 1) == 0)
                    send_req(write_req($urandom_range(0, area - 1), rand_chan(),
                                       rand_chan(), rand_chan(), rand_chan()));
                else
                    send_req(write_req($urandom_range(0, MEM_DEPTH - 1), rand_chan(),
                                       rand_chan(), rand_chan(), rand_chan()));
            end else begin
                send_req(sample_req(rand_coord(), rand_coord()));
            end
        end
    endtask

    initial begin
        int unsigned area;
        // synchronous reset held low at the start, once
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < PHASES; ph++) begin
            // block is idle here: after reset or after the previous drain
            reg_write(REG_TEX_WIDTH, phase_w[ph]);
            reg_write(REG_TEX_HEIGHT, phase_h[ph]);
            area = eff_size(phase_w[ph], MAX_W) * eff_size(phase_h[ph], MAX_H);
            fill_region(area);
            if (ph == 0)
                directed_part();
            random_part(area, ph % 3 == 1);
            settle_idle();
        end

        $display("covered %0d texel writes and %0d filtered samples over %0d size settings",
                 write_count, sample_count, PHASES);
        $display("sizes from 1x1 up to 64 on either axis incl. zero and oversize values,");
        $display("with random gaps and stalls on both sides");
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
